// File: hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Holds the widths, the phase encoding, the register map and the
// fixed-point constants for the pulse to distance conversion.
// ----------------------------------------------------------------------------
package uer_pkg;

  // counter widths
  localparam int COUNT_WIDTH = 20;
  localparam int PULSE_WIDTH = 16;

  // register field widths
  localparam int TIMEOUT_WIDTH = 20;
  localparam int LIMIT_WIDTH   = 16;
  localparam int TRIG_WIDTH    = 8;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DAT_WIDTH = 20;

  // result field widths
  localparam int STATUS_WIDTH = 3;
  localparam int OUT_W        = 16;

  // stream data widths, padded to whole bytes
  localparam int IN_FIELDS_W  = 3;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 + STATUS_WIDTH + OUT_W + OUT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // saturation values
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [PULSE_WIDTH-1:0] PUL_MAX = {PULSE_WIDTH{1'b1}};

  // distance = pulse * 17 / 10, as multiply by a rounded-up reciprocal and shift;
  // exact for pulses below 2^25
  localparam int DIST_MUL_W = 28;
  localparam int DIST_SHIFT = 27;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = 28'd228170138;
  localparam int DIST_PROD_W = PULSE_WIDTH + DIST_MUL_W;

  // register reset values
  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RST   = 20'd100000;
  localparam logic [LIMIT_WIDTH-1:0]   MIN_PULSE_RST = 16'd58;
  localparam logic [LIMIT_WIDTH-1:0]   MAX_PULSE_RST = 16'd38000;
  localparam logic [TRIG_WIDTH-1:0]    TRIG_LOW_RST  = 8'd2;
  localparam logic [TRIG_WIDTH-1:0]    TRIG_HIGH_RST = 8'd10;

  // register map
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_TIMEOUT   = 3'd0,
    REG_MIN_PULSE = 3'd1,
    REG_MAX_PULSE = 3'd2,
    REG_TRIG_LOW  = 3'd3,
    REG_TRIG_HIGH = 3'd4
  } reg_idx_t;

  // measurement phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TLOW  = 3'd1,
    PH_THIGH = 3'd2,
    PH_WLOW  = 3'd3,
    PH_WRISE = 3'd4,
    PH_WFALL = 3'd5
  } phase_t;

  // status codes
  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK      = 3'd0,
    ST_STUCK   = 3'd1,
    ST_NO_RISE = 3'd2,
    ST_NO_FALL = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

endpackage

// File: hw/rtl/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit: echo-pulse ranging controller
// Drives the trigger sequence, times the echo pulse and converts it to a
// distance in hundredths of a centimeter.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one request per clock sample: tdata holds start_req, echo, tick
//          from bit 0 up, padded to a byte.
//   out_*  one result per request: trigger, busy, done, status, last pulse
//          width and last good distance, packed from bit 0 up.
//   cfg_*  register writes (index, data), ready whenever out of reset, applied at once;
//          write only while no request is in flight.
//   Each request is evaluated in the cycle it is taken and its result is
//   held in the output register; one request per cycle while results are taken.
//   Critical path: the 16 x 28 bit reciprocal multiply for the distance.
//   When the receiver stalls, the result is held and in_tready drops until
//   it is taken; in_tready stays high while out_tready is high.
//   Reset (rst_n low, synchronous) holds in_tready and cfg_ready low, returns
//   to idle, clears the last pulse, distance and status, and loads the defaults.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit
  import uer_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_W-1:0]     in_tdata,   // start_req, echo, tick
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_W-1:0]    out_tdata,  // trigger, busy_res, done_res,
                                               // status, pulse_ticks,
                                               // distance_centi
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DAT_WIDTH-1:0] cfg_data
);

  // configuration registers
  logic [TIMEOUT_WIDTH-1:0] timeout_r;
  logic [LIMIT_WIDTH-1:0]   min_pulse_r;
  logic [LIMIT_WIDTH-1:0]   max_pulse_r;
  logic [TRIG_WIDTH-1:0]    trig_low_r;
  logic [TRIG_WIDTH-1:0]    trig_high_r;

  // measurement state
  phase_t                   phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]   phase_cnt_r, phase_cnt_nxt;
  logic [PULSE_WIDTH-1:0]   pulse_cnt_r, pulse_cnt_nxt;
  logic [PULSE_WIDTH-1:0]   last_pulse_r, last_pulse_nxt;
  logic [OUT_W-1:0]         last_dist_r, last_dist_nxt;
  status_t                  last_status_r, last_status_nxt;
  logic                     done;

  // output register
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  logic                     in_accept;
  logic                     start_req, echo, tick;
  logic [COUNT_WIDTH-1:0]   cnt_inc;
  logic                     timed_out;
  logic [COUNT_WIDTH-1:0]   trig_lim;
  logic [DIST_PROD_W-1:0]   dist_prod;
  logic [31:0]              dist_full;
  logic [OUT_W-1:0]         dist_sat;
  logic                     pulse_ok;
  logic [OUT_W-1:0]         pulse_out;

  assign start_req = in_tdata[0];
  assign echo      = in_tdata[1];
  assign tick      = in_tdata[2];

  // handshake: take a request whenever the output register is free or drains
  assign in_tready  = rst_n && (!out_valid_r || out_tready);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = rst_n;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      min_pulse_r <= MIN_PULSE_RST;
      max_pulse_r <= MAX_PULSE_RST;
      trig_low_r  <= TRIG_LOW_RST;
      trig_high_r <= TRIG_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMEOUT:   timeout_r   <= cfg_data[TIMEOUT_WIDTH-1:0];
        REG_MIN_PULSE: min_pulse_r <= cfg_data[LIMIT_WIDTH-1:0];
        REG_MAX_PULSE: max_pulse_r <= cfg_data[LIMIT_WIDTH-1:0];
        REG_TRIG_LOW:  trig_low_r  <= cfg_data[TRIG_WIDTH-1:0];
        REG_TRIG_HIGH: trig_high_r <= cfg_data[TRIG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // wait-phase tick counter with saturation and timeout check
  assign cnt_inc   = (phase_cnt_r != CNT_MAX) ? phase_cnt_r + 1'b1 : phase_cnt_r;
  assign timed_out = (32'(cnt_inc) >= 32'(timeout_r)) || (cnt_inc == CNT_MAX);

  // trigger phase limit
  assign trig_lim = (phase_r == PH_TLOW) ? COUNT_WIDTH'(trig_low_r)
                                         : COUNT_WIDTH'(trig_high_r);

  // pulse range check and distance conversion
  assign pulse_ok  = (32'(pulse_cnt_r) >= 32'(min_pulse_r)) &&
                     (32'(pulse_cnt_r) <= 32'(max_pulse_r));
  assign dist_prod = DIST_PROD_W'(pulse_cnt_r) * DIST_PROD_W'(DIST_MUL);
  assign dist_full = 32'(dist_prod >> DIST_SHIFT);
  assign dist_sat  = (dist_full > 32'hFFFF) ? {OUT_W{1'b1}} : dist_full[OUT_W-1:0];

  // next state of the measurement sequence
  always_comb begin
    phase_nxt       = phase_r;
    phase_cnt_nxt   = phase_cnt_r;
    pulse_cnt_nxt   = pulse_cnt_r;
    last_pulse_nxt  = last_pulse_r;
    last_dist_nxt   = last_dist_r;
    last_status_nxt = last_status_r;
    done            = 1'b0;
    case (phase_r)
      PH_TLOW, PH_THIGH: begin
        if (phase_cnt_r >= trig_lim) begin
          phase_nxt     = (phase_r == PH_TLOW) ? PH_THIGH : PH_WLOW;
          phase_cnt_nxt = '0;
        end else if (tick && phase_cnt_r != CNT_MAX) begin
          phase_cnt_nxt = phase_cnt_r + 1'b1;
        end
      end
      PH_WLOW: begin
        if (!echo) begin
          phase_nxt     = PH_WRISE;
          phase_cnt_nxt = '0;
        end else if (tick) begin
          phase_cnt_nxt = cnt_inc;
          if (timed_out) begin
            last_status_nxt = ST_STUCK;
            last_pulse_nxt  = '0;
            phase_nxt       = PH_IDLE;
            phase_cnt_nxt   = '0;
            done            = 1'b1;
          end
        end
      end
      PH_WRISE: begin
        if (echo) begin
          phase_nxt     = PH_WFALL;
          phase_cnt_nxt = '0;
          pulse_cnt_nxt = '0;
        end else if (tick) begin
          phase_cnt_nxt = cnt_inc;
          if (timed_out) begin
            last_status_nxt = ST_NO_RISE;
            last_pulse_nxt  = '0;
            phase_nxt       = PH_IDLE;
            phase_cnt_nxt   = '0;
            done            = 1'b1;
          end
        end
      end
      PH_WFALL: begin
        if (!echo) begin
          // falling edge: judge the pulse
          phase_nxt     = PH_IDLE;
          phase_cnt_nxt = '0;
          done          = 1'b1;
          if (pulse_ok) begin
            last_dist_nxt   = dist_sat;
            last_pulse_nxt  = pulse_cnt_r;
            last_status_nxt = ST_OK;
          end else begin
            last_status_nxt = ST_RANGE;
            last_pulse_nxt  = '0;
          end
        end else if (tick) begin
          if (pulse_cnt_r != PUL_MAX) pulse_cnt_nxt = pulse_cnt_r + 1'b1;
          phase_cnt_nxt = cnt_inc;
          if (timed_out) begin
            last_status_nxt = ST_NO_FALL;
            last_pulse_nxt  = '0;
            phase_nxt       = PH_IDLE;
            phase_cnt_nxt   = '0;
            done            = 1'b1;
          end
        end
      end
      default: begin
        // idle and unused codes
        phase_cnt_nxt = '0;
        phase_nxt     = start_req ? PH_TLOW : PH_IDLE;
      end
    endcase
  end

  // result fields from the state after this request
  assign pulse_out = (32'(last_pulse_nxt) > 32'hFFFF) ? {OUT_W{1'b1}}
                                                       : OUT_W'(last_pulse_nxt);

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OUT_FIELDS_W-1:0] = {last_dist_nxt, pulse_out, last_status_nxt, done,
                                      (phase_nxt != PH_IDLE), (phase_nxt == PH_THIGH)};
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      phase_cnt_r   <= '0;
      pulse_cnt_r   <= '0;
      last_pulse_r  <= '0;
      last_dist_r   <= '0;
      last_status_r <= ST_OK;
    end else if (in_accept) begin
      phase_r       <= phase_nxt;
      phase_cnt_r   <= phase_cnt_nxt;
      pulse_cnt_r   <= pulse_cnt_nxt;
      last_pulse_r  <= last_pulse_nxt;
      last_dist_r   <= last_dist_nxt;
      last_status_r <= last_status_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the ultrasonic echo ranger
// Builds measurement sequences (trigger, echo low, rise, pulse, fall) with
// random tick gaps, plus broken sequences and noise, under several register
// settings. A cycle-level predictor tracks phase and counters and every
// reading on the result stream is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import uer_pkg::*;

  // one input request, packed from bit 0 up
  typedef struct packed {
    logic tick;
    logic echo;
    logic start;
  } sample_t;

  // one reading, packed from bit 0 up
  typedef struct packed {
    logic [OUT_W-1:0] distance;
    logic [OUT_W-1:0] pulse;
    status_t          status;
    logic             done;
    logic             busy;
    logic             trigger;
  } reading_t;

  // shape of one queued measurement
  typedef enum {
    EC_PULSE,
    EC_STUCK,
    EC_NO_RISE,
    EC_NO_FALL,
    EC_NOISE
  } echo_case_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_W-1:0]     in_tdata = '0;   // start_req, echo, tick
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]    out_tdata;       // trigger, busy_res, done_res,
                                             // status, pulse_ticks,
                                             // distance_centi
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = REG_TIMEOUT;
  logic [CFG_DAT_WIDTH-1:0] cfg_data = '0;

  // stimulus and expectation stores
  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned fail_cnt = 0;
  int unsigned ends_by_status[8];

  // predictor copy of the registers
  logic [TIMEOUT_WIDTH-1:0] tmo;
  logic [LIMIT_WIDTH-1:0]   pmin;
  logic [LIMIT_WIDTH-1:0]   pmax;
  logic [TRIG_WIDTH-1:0]    tlow;
  logic [TRIG_WIDTH-1:0]    thigh;

  // predictor copy of the measurement state
  phase_t                 ph;
  logic [COUNT_WIDTH-1:0] ph_cnt;
  logic [PULSE_WIDTH-1:0] echo_cnt;
  logic [PULSE_WIDTH-1:0] good_pulse;
  logic [OUT_W-1:0]       good_dist;
  status_t                last_st;

  reading_t want_r;
  reading_t exp_r;
  reading_t got_r;

  // sender state
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  // receiver state
  int unsigned hold_left = 0;
  int unsigned results_taken = 0;
  int unsigned next_hold = 150;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  ultrasonic_echo_ranger_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one tick in a wait phase, returns 1 on timeout
  function automatic logic wait_expired();
    if (ph_cnt != CNT_MAX) ph_cnt++;
    return (ph_cnt >= tmo) || (ph_cnt == CNT_MAX);
  endfunction

  function automatic void end_error(status_t code);
    last_st    = code;
    good_pulse = '0;
    ph         = PH_IDLE;
    ph_cnt     = '0;
  endfunction

  function automatic reading_t next_reading(sample_t s);
    logic        done;
    logic [COUNT_WIDTH-1:0] lim;
    int unsigned d;
    reading_t    r;
    done = 1'b0;
    case (ph)
      PH_TLOW, PH_THIGH: begin
        lim = (ph == PH_TLOW) ? COUNT_WIDTH'(tlow) : COUNT_WIDTH'(thigh);
        if (ph_cnt >= lim) begin
          ph     = (ph == PH_TLOW) ? PH_THIGH : PH_WLOW;
          ph_cnt = '0;
        end else if (s.tick && ph_cnt != CNT_MAX) begin
          ph_cnt++;
        end
      end
      PH_WLOW: begin
        if (!s.echo) begin
          ph     = PH_WRISE;
          ph_cnt = '0;
        end else if (s.tick) begin
          if (wait_expired()) begin
            end_error(ST_STUCK);
            done = 1'b1;
          end
        end
      end
      PH_WRISE: begin
        if (s.echo) begin
          ph       = PH_WFALL;
          ph_cnt   = '0;
          echo_cnt = '0;
        end else if (s.tick) begin
          if (wait_expired()) begin
            end_error(ST_NO_RISE);
            done = 1'b1;
          end
        end
      end
      PH_WFALL: begin
        if (!s.echo) begin
          done = 1'b1;
          if (echo_cnt < pmin || echo_cnt > pmax) begin
            end_error(ST_RANGE);
          end else begin
            // hundredths of a cm, saturated to the field
            d          = 32'(echo_cnt) * 32'd17 / 32'd10;
            good_dist  = (d > 32'd65535) ? 16'hFFFF : d[OUT_W-1:0];
            good_pulse = echo_cnt;
            last_st    = ST_OK;
            ph         = PH_IDLE;
            ph_cnt     = '0;
          end
        end else if (s.tick) begin
          if (echo_cnt != PUL_MAX) echo_cnt++;
          if (wait_expired()) begin
            end_error(ST_NO_FALL);
            done = 1'b1;
          end
        end
      end
      default: begin
        ph_cnt = '0;
        ph     = s.start ? PH_TLOW : PH_IDLE;
      end
    endcase
    r.trigger  = (ph == PH_THIGH);
    r.busy     = (ph != PH_IDLE);
    r.done     = done;
    r.status   = last_st;
    r.pulse    = OUT_W'(good_pulse);
    r.distance = good_dist;
    return r;
  endfunction

  // register writes and accepted requests feed the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      tmo        = TIMEOUT_RST;
      pmin       = MIN_PULSE_RST;
      pmax       = MAX_PULSE_RST;
      tlow       = TRIG_LOW_RST;
      thigh      = TRIG_HIGH_RST;
      ph         = PH_IDLE;
      ph_cnt     = '0;
      echo_cnt   = '0;
      good_pulse = '0;
      good_dist  = '0;
      last_st    = ST_OK;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TIMEOUT:   tmo   = cfg_data[TIMEOUT_WIDTH-1:0];
          REG_MIN_PULSE: pmin  = cfg_data[LIMIT_WIDTH-1:0];
          REG_MAX_PULSE: pmax  = cfg_data[LIMIT_WIDTH-1:0];
          REG_TRIG_LOW:  tlow  = cfg_data[TRIG_WIDTH-1:0];
          REG_TRIG_HIGH: thigh = cfg_data[TRIG_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want_r = next_reading(sample_t'(in_tdata[IN_FIELDS_W-1:0]));
        if (want_r.done) ends_by_status[want_r.status]++;
        expected_readings.push_back(want_r);
        accepted_total++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of requests with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= IN_DATA_W'(pending_samples.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) results_taken++;
      if (hold_left == 0 && results_taken >= next_hold) begin
        hold_left = 300;
        next_hold = next_hold + 5000;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3);
        mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(3) != 0);
          2:       out_tready <= ~out_tready;
          default: out_tready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each reading with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_r = reading_t'(out_tdata[OUT_FIELDS_W-1:0]);
      checked_total++;
      if (expected_readings.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("ERROR: reading %0d with nothing expected: trig %0b busy %0b done %0b",
                   checked_total, got_r.trigger, got_r.busy, got_r.done);
      end else begin
        exp_r = expected_readings.pop_front();
        if (got_r.trigger !== exp_r.trigger || got_r.busy !== exp_r.busy ||
            got_r.done !== exp_r.done || got_r.status !== exp_r.status ||
            got_r.pulse !== exp_r.pulse || got_r.distance !== exp_r.distance) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("ERROR: reading %0d exp trig %0b busy %0b done %0b st %0d pulse %0d dist %0d",
                     checked_total, exp_r.trigger, exp_r.busy, exp_r.done,
                     exp_r.status, exp_r.pulse, exp_r.distance);
            $display("       got          trig %0b busy %0b done %0b st %0d pulse %0d dist %0d",
                     got_r.trigger, got_r.busy, got_r.done, got_r.status, got_r.pulse,
                     got_r.distance);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic rbit();
    return 1'($urandom_range(1));
  endfunction

  // start requests while busy should be ignored
  function automatic logic stray_start();
    return ($urandom_range(7) == 0);
  endfunction

  function automatic void add_sample(logic st, logic ec, logic tk);
    sample_t s;
    s.start = st;
    s.echo  = ec;
    s.tick  = tk;
    pending_samples.push_back(s);
    queued_total++;
  endfunction

  // n ticked requests at a fixed echo level, with idle requests mixed in
  function automatic void add_ticked(int unsigned n, logic lvl);
    int unsigned k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(3) == 0) begin
        add_sample(stray_start(), lvl, 1'b0);
      end else begin
        add_sample(stray_start(), lvl, 1'b1);
        k++;
      end
    end
  endfunction

  // one measurement as seen on the echo pin, followed by a short idle gap
  function automatic void queue_measurement(echo_case_t kind, int unsigned width);
    int unsigned n_tmo;
    int unsigned n;
    int unsigned i;
    n_tmo = (tmo == 0) ? 1 : 32'(tmo);
    if (kind == EC_NOISE) begin
      n = $urandom_range(1, 30);
      for (i = 0; i < n; i++) add_sample(rbit(), rbit(), rbit());
      return;
    end
    // start, trigger low, trigger high
    add_sample(1'b1, rbit(), rbit());
    add_ticked(32'(tlow), 1'b0);
    add_sample(stray_start(), 1'b0, rbit());
    add_ticked(32'(thigh), 1'b0);
    add_sample(stray_start(), 1'b0, rbit());
    case (kind)
      EC_STUCK: add_ticked(n_tmo, 1'b1);
      EC_NO_RISE: begin
        add_sample(stray_start(), 1'b0, rbit());
        add_ticked(n_tmo, 1'b0);
      end
      default: begin
        // echo low, rise, high time, fall
        add_sample(stray_start(), 1'b0, rbit());
        add_ticked((tmo > 3) ? $urandom_range(2) : 0, 1'b0);
        add_sample(stray_start(), 1'b1, rbit());
        if (kind == EC_NO_FALL) begin
          add_ticked(n_tmo, 1'b1);
        end else begin
          add_ticked(width, 1'b1);
          add_sample(stray_start(), 1'b0, rbit());
        end
      end
    endcase
    n = $urandom_range(3);
    for (i = 0; i < n; i++) add_sample(1'b0, rbit(), rbit());
  endfunction

  function automatic echo_case_t pick_case();
    int unsigned r;
    r = $urandom_range(9);
    if (tmo > 200 || r < 6) return EC_PULSE;
    case (r)
      6:       return EC_STUCK;
      7:       return EC_NO_RISE;
      8:       return EC_NO_FALL;
      default: return EC_NOISE;
    endcase
  endfunction

  // pulse widths cluster around the limits, below a nonzero timeout and at most 80
  function automatic int unsigned pick_width();
    int unsigned hi;
    int unsigned w;
    hi = (tmo == 0) ? 0 : ((tmo - 1 > 80) ? 80 : tmo - 1);
    case ($urandom_range(5))
      0:       w = (pmin == 0) ? 0 : pmin - 1;
      1:       w = pmin;
      2:       w = pmax;
      3:       w = pmax + 1;
      default: w = $urandom_range(hi);
    endcase
    return (w > hi) ? hi : w;
  endfunction

  // wait until every request is taken and every reading checked
  task automatic settle();
    while (accepted_total != queued_total || expected_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ranging(int unsigned t, int unsigned mn, int unsigned mx,
                             int unsigned lo, int unsigned hi);
    reg_idx_t                 idx[5];
    logic [CFG_DAT_WIDTH-1:0] vals[5];
    int                       i;
    idx  = '{REG_TIMEOUT, REG_MIN_PULSE, REG_MAX_PULSE, REG_TRIG_LOW, REG_TRIG_HIGH};
    vals = '{CFG_DAT_WIDTH'(t), CFG_DAT_WIDTH'(mn), CFG_DAT_WIDTH'(mx),
             CFG_DAT_WIDTH'(lo), CFG_DAT_WIDTH'(hi)};
    for (i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned base;
    int          i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: idle noise, pulse at the lower limit, just below, mid range
    for (i = 0; i < 3; i++) add_sample(1'b0, rbit(), rbit());
    queue_measurement(EC_PULSE, 58);
    queue_measurement(EC_PULSE, 57);
    queue_measurement(EC_PULSE, 100);
    settle();

    // short phases: every ending, both range errors, zero trigger low
    set_ranging(6, 2, 4, 0, 1);
    queue_measurement(EC_PULSE, 2);
    queue_measurement(EC_PULSE, 4);
    queue_measurement(EC_PULSE, 1);
    queue_measurement(EC_PULSE, 5);
    queue_measurement(EC_STUCK, 0);
    queue_measurement(EC_NO_RISE, 0);
    queue_measurement(EC_NO_FALL, 0);
    queue_measurement(EC_NOISE, 0);
    settle();

    // longest trigger low, one-tick timeout, zero-width pulse window
    set_ranging(1, 0, 0, 255, 2);
    queue_measurement(EC_PULSE, 0);
    settle();

    // zero timeout and zero trigger high, window at the top
    set_ranging(0, 65535, 65535, 0, 0);
    queue_measurement(EC_PULSE, 0);
    queue_measurement(EC_STUCK, 0);
    queue_measurement(EC_NO_RISE, 0);
    queue_measurement(EC_NO_FALL, 0);
    settle();

    // widest timeout and full pulse window
    set_ranging(1048575, 0, 65535, 1, 1);
    queue_measurement(EC_PULSE, 0);
    settle();

    // random settings with mostly well-formed measurements
    base = queued_total;
    while (queued_total - base < 250) begin
      set_ranging(($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(8, 60),
                  $urandom_range(12), 0, $urandom_range(3), $urandom_range(3));
      // max limit sometimes below min so every pulse is out of range
      set_ranging(tmo, pmin,
                  ($urandom_range(3) == 0) ? $urandom_range(pmin) : $urandom_range(40, pmin),
                  tlow, thigh);
      for (i = 0; i < 3; i++) queue_measurement(pick_case(), pick_width());
      settle();
    end

    $display("Run covered %0d samples and %0d checked readings", queued_total, checked_total);
    $display("Measurements ended: ok %0d, stuck high %0d, no rise %0d, no fall %0d, range %0d",
             ends_by_status[ST_OK], ends_by_status[ST_STUCK], ends_by_status[ST_NO_RISE],
             ends_by_status[ST_NO_FALL], ends_by_status[ST_RANGE]);
    if (fail_cnt == 0 && expected_readings.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("Timed out with %0d readings outstanding", expected_readings.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/uer_pkg.sv
hw/rtl/ultrasonic_echo_ranger_unit.sv
dv/tb_top.sv
